/* src/sssp_pkg.sv */
// sssp_pkg.sv
// Sizes, command codes and the controller/datapath command and status
// structs for the single-source shortest-path block. No dependencies.
package sssp_pkg;

    localparam int MAX_NODES = 32;
    localparam int DIST_BITS = 24;

    localparam int KEY_W   = 8;
    localparam int CMD_W   = 2;
    localparam int COST_W  = 16;
    localparam int EDGE_W  = COST_W + 1;
    localparam int SLOT_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int EDGES   = MAX_NODES * MAX_NODES;
    localparam int EADDR_W = $clog2(EDGES);

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [EDGE_W-1:0]    NO_EDGE  = {1'b1, {COST_W{1'b0}}};

    localparam logic [CMD_W-1:0] CMD_ADD_NODE = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_RUN      = CMD_W'(2);

    typedef enum logic [1:0] {
        SCAN_LOOKUP,
        SCAN_RELAX,
        SCAN_EMIT
    } t_scan;

    typedef struct packed {
        logic  clr_step;
        logic  take;
        logic  scan_start;
        logic  scan_run;
        t_scan scan_kind;
        logic  node_add;
        logic  edge_rd;
        logic  edge_upd;
        logic  run_init;
        logic  settle;
        logic  emit_reset;
        logic  emit;
    } t_dp_cmd;

    typedef struct packed {
        logic             clr_done;
        logic             scan_done;
        logic             found_a;
        logic             found_b;
        logic             full;
        logic             min_found;
        logic             emit_done;
        logic             out_free;
        logic [CMD_W-1:0] cmd;
    } t_dp_sts;

endpackage

/* src/sssp_ram.sv */
// sssp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sssp_ctrl.sv */
// sssp_ctrl.sv
// Controller state machine: sequences table clear, lookups, edge updates, relax rounds
// and result scans. Depends on sssp_pkg.
module sssp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sssp_pkg::t_dp_sts i_sts,
    output sssp_pkg::t_dp_cmd o_ctl
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EDGE_RD,
        S_EDGE_UPD,
        S_RUN_INIT,
        S_RELAX,
        S_EMIT,
        S_EMIT_HOLD
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_stall;
    sssp_pkg::t_dp_cmd ctl;

    always_comb begin
        ctl           = '0;
        ctl.scan_kind = sssp_pkg::SCAN_LOOKUP;
        n_state       = r_state;
        unique case (r_state)
            S_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && !r_stall) begin
                    ctl.take       = 1'b1;
                    ctl.scan_start = 1'b1;
                    n_state        = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                ctl.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_IDLE;
                    unique case (i_sts.cmd)
                        sssp_pkg::CMD_ADD_NODE: begin
                            ctl.node_add = !i_sts.found_a && !i_sts.full;
                        end
                        sssp_pkg::CMD_ADD_EDGE: begin
                            if (i_sts.found_a && i_sts.found_b) begin
                                n_state = S_EDGE_RD;
                            end
                        end
                        sssp_pkg::CMD_RUN: begin
                            if (i_sts.found_a) begin
                                n_state = S_RUN_INIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE_RD: begin
                ctl.edge_rd = 1'b1;
                n_state     = S_EDGE_UPD;
            end
            S_EDGE_UPD: begin
                ctl.edge_upd = 1'b1;
                n_state      = S_IDLE;
            end
            S_RUN_INIT: begin
                ctl.run_init   = 1'b1;
                ctl.scan_start = 1'b1;
                n_state        = S_RELAX;
            end
            S_RELAX: begin
                ctl.scan_kind = sssp_pkg::SCAN_RELAX;
                ctl.scan_run  = 1'b1;
                if (i_sts.scan_done) begin
                    ctl.scan_start = 1'b1;
                    if (i_sts.min_found) begin
                        ctl.settle = 1'b1;
                    end else begin
                        ctl.emit_reset = 1'b1;
                        n_state        = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                ctl.scan_kind = sssp_pkg::SCAN_EMIT;
                if (i_sts.emit_done) begin
                    n_state = S_IDLE;
                end else begin
                    ctl.scan_run = 1'b1;
                    if (i_sts.scan_done) begin
                        if (i_sts.out_free) begin
                            ctl.emit       = 1'b1;
                            ctl.scan_start = 1'b1;
                        end else begin
                            n_state = S_EMIT_HOLD;
                        end
                    end
                end
            end
            S_EMIT_HOLD: begin
                ctl.scan_kind = sssp_pkg::SCAN_EMIT;
                if (i_sts.out_free) begin
                    ctl.emit       = 1'b1;
                    ctl.scan_start = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;
    assign o_ctl   = ctl;

endmodule

/* src/sssp_dp.sv */
// sssp_dp.sv
// Datapath: node key, distance and edge memories, scan pipeline, relax
// and minimum logic, result register. Depends on sssp_pkg, sssp_ram.
module sssp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sssp_pkg::t_dp_cmd                   i_ctl,
    output sssp_pkg::t_dp_sts                   o_sts,
    input  logic [sssp_pkg::CMD_W-1:0]          i_cmd,
    input  logic [sssp_pkg::KEY_W-1:0]          i_key_a,
    input  logic [sssp_pkg::KEY_W-1:0]          i_key_b,
    input  logic [sssp_pkg::COST_W-1:0]         i_edge_cost,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [sssp_pkg::KEY_W-1:0]          o_node_key,
    output logic [sssp_pkg::DIST_BITS-1:0]      o_path_cost,
    output logic                                o_reachable,
    output logic                                o_last
);

    localparam int NN  = sssp_pkg::MAX_NODES;
    localparam int DW  = sssp_pkg::DIST_BITS;
    localparam int KW  = sssp_pkg::KEY_W;
    localparam int CW  = sssp_pkg::COST_W;
    localparam int EW  = sssp_pkg::EDGE_W;
    localparam int SW  = sssp_pkg::SLOT_W;
    localparam int NW  = sssp_pkg::CNT_W;
    localparam int EAW = sssp_pkg::EADDR_W;
    localparam logic [EAW-1:0] ROW_STRIDE = EAW'(NN);

    // item latch
    logic [sssp_pkg::CMD_W-1:0] r_cmd;
    logic [KW-1:0]              r_key_a;
    logic [KW-1:0]              r_key_b;
    logic [CW-1:0]              r_cost;

    logic [NW-1:0]  r_count;
    logic [EAW-1:0] r_clr;

    // scan pipeline
    logic [NW-1:0] r_idx;
    logic          r_pv;
    logic [SW-1:0] r_pidx;

    logic          r_found_a;
    logic          r_found_b;
    logic [SW-1:0] r_slot_a;
    logic [SW-1:0] r_slot_b;

    logic [NN-1:0] r_cv;
    logic [NN-1:0] r_st;
    logic [SW-1:0] r_pick;
    logic [DW-1:0] r_pick_cost;
    logic          r_min_found;
    logic [SW-1:0] r_min_slot;
    logic [DW-1:0] r_min_cost;

    logic          r_e_found;
    logic [KW-1:0] r_e_key;
    logic [DW-1:0] r_e_cost;
    logic          r_e_cv;
    logic          r_have_prev;
    logic [KW-1:0] r_prev_key;
    logic [NW-1:0] r_out_cnt;

    logic          r_ovalid;
    logic [KW-1:0] r_okey;
    logic [DW-1:0] r_ocost;
    logic          r_oreach;
    logic          r_olast;

    logic [KW-1:0] node_q;
    logic [DW-1:0] cost_q;
    logic [EW-1:0] edge_q;

    logic           issue;
    logic [SW-1:0]  scan_addr;
    logic [EAW-1:0] edge_ab;
    logic [EAW-1:0] edge_raddr;
    logic           edge_we;
    logic [EAW-1:0] edge_waddr;
    logic [EW-1:0]  edge_wdata;
    logic           cost_we;
    logic [SW-1:0]  cost_waddr;
    logic [DW-1:0]  cost_wdata;
    logic [DW:0]    relax_sum;
    logic [DW-1:0]  relax_c;
    logic           cv_j;
    logic           st_j;
    logic           relax_wr;
    logic           new_cv;
    logic [DW-1:0]  new_c;
    logic           min_take;
    logic           lk_a;
    logic           lk_b;
    logic           cand;
    logic           edge_wr_upd;
    logic [NN-1:0]  src_onehot;

    assign issue     = i_ctl.scan_run && (r_idx < r_count);
    assign scan_addr = r_idx[SW-1:0];
    assign edge_ab   = EAW'(r_slot_a) * ROW_STRIDE + EAW'(r_slot_b);

    always_comb begin
        cv_j      = r_cv[r_pidx];
        st_j      = r_st[r_pidx];
        relax_sum = {1'b0, r_pick_cost} + {{(DW + 1 - CW){1'b0}}, edge_q[CW-1:0]};
        relax_c   = (relax_sum > {1'b0, sssp_pkg::DIST_MAX}) ? sssp_pkg::DIST_MAX
                                                             : relax_sum[DW-1:0];
        relax_wr  = r_pv && (i_ctl.scan_kind == sssp_pkg::SCAN_RELAX) && !edge_q[CW]
                    && (!cv_j || (relax_c < cost_q));
        new_cv    = relax_wr || cv_j;
        new_c     = relax_wr ? relax_c : cost_q;
        min_take  = r_pv && (i_ctl.scan_kind == sssp_pkg::SCAN_RELAX) && new_cv && !st_j
                    && (!r_min_found || (new_c < r_min_cost));
        lk_a      = r_pv && (i_ctl.scan_kind == sssp_pkg::SCAN_LOOKUP) && (node_q == r_key_a);
        lk_b      = r_pv && (i_ctl.scan_kind == sssp_pkg::SCAN_LOOKUP) && (node_q == r_key_b);
        cand      = r_pv && (i_ctl.scan_kind == sssp_pkg::SCAN_EMIT) && (r_pidx != r_slot_a)
                    && (!r_have_prev || (node_q > r_prev_key))
                    && (!r_e_found || (node_q < r_e_key));
        edge_wr_upd = i_ctl.edge_upd && (edge_q[CW] || (r_cost < edge_q[CW-1:0]));
        src_onehot           = '0;
        src_onehot[r_slot_a] = 1'b1;
    end

    always_comb begin
        edge_we    = i_ctl.clr_step || edge_wr_upd;
        edge_waddr = i_ctl.clr_step ? r_clr : edge_ab;
        edge_wdata = i_ctl.clr_step ? sssp_pkg::NO_EDGE : {1'b0, r_cost};
        edge_raddr = i_ctl.edge_rd ? edge_ab : (EAW'(r_pick) * ROW_STRIDE + EAW'(scan_addr));
        cost_we    = i_ctl.run_init || relax_wr;
        cost_waddr = i_ctl.run_init ? r_slot_a : r_pidx;
        cost_wdata = i_ctl.run_init ? '0 : relax_c;
    end

    sssp_ram #(.WIDTH(KW), .DEPTH(NN)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.node_add),
        .i_wr_addr (r_count[SW-1:0]),
        .i_wr_data (r_key_a),
        .i_rd_addr (scan_addr),
        .o_rd_data (node_q)
    );

    sssp_ram #(.WIDTH(DW), .DEPTH(NN)) u_cost_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cost_we),
        .i_wr_addr (cost_waddr),
        .i_wr_data (cost_wdata),
        .i_rd_addr (scan_addr),
        .o_rd_data (cost_q)
    );

    sssp_ram #(.WIDTH(EW), .DEPTH(sssp_pkg::EDGES)) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (edge_we),
        .i_wr_addr (edge_waddr),
        .i_wr_data (edge_wdata),
        .i_rd_addr (edge_raddr),
        .o_rd_data (edge_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_found_a   <= 1'b0;
            r_found_b   <= 1'b0;
            r_min_found <= 1'b0;
            r_e_found   <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_cnt   <= '0;
            r_cv        <= '0;
            r_st        <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_ctl.clr_step) begin
                r_clr <= r_clr + EAW'(1);
            end
            if (i_ctl.node_add) begin
                r_count <= r_count + NW'(1);
            end
            if (i_ctl.scan_start) begin
                r_idx       <= '0;
                r_pv        <= 1'b0;
                r_found_a   <= 1'b0;
                r_found_b   <= 1'b0;
                r_min_found <= 1'b0;
                r_e_found   <= 1'b0;
            end else if (i_ctl.scan_run) begin
                r_pv <= issue;
                if (issue) begin
                    r_idx <= r_idx + NW'(1);
                end
                if (lk_a) begin
                    r_found_a <= 1'b1;
                end
                if (lk_b) begin
                    r_found_b <= 1'b1;
                end
                if (min_take) begin
                    r_min_found <= 1'b1;
                end
                if (cand) begin
                    r_e_found <= 1'b1;
                end
            end
            if (i_ctl.run_init) begin
                r_cv <= src_onehot;
                r_st <= src_onehot;
            end else begin
                if (relax_wr) begin
                    r_cv[r_pidx] <= 1'b1;
                end
                if (i_ctl.settle) begin
                    r_st[r_min_slot] <= 1'b1;
                end
            end
            if (i_ctl.emit_reset) begin
                r_out_cnt   <= '0;
                r_have_prev <= 1'b0;
            end else if (i_ctl.emit) begin
                r_out_cnt   <= r_out_cnt + NW'(1);
                r_have_prev <= 1'b1;
            end
            if (i_ctl.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cmd   <= i_cmd;
            r_key_a <= i_key_a;
            r_key_b <= i_key_b;
            r_cost  <= i_edge_cost;
        end
        if (issue) begin
            r_pidx <= scan_addr;
        end
        if (lk_a) begin
            r_slot_a <= r_pidx;
        end
        if (lk_b) begin
            r_slot_b <= r_pidx;
        end
        if (min_take) begin
            r_min_slot <= r_pidx;
            r_min_cost <= new_c;
        end
        if (i_ctl.run_init) begin
            r_pick      <= r_slot_a;
            r_pick_cost <= '0;
        end else if (i_ctl.settle) begin
            r_pick      <= r_min_slot;
            r_pick_cost <= r_min_cost;
        end
        if (cand) begin
            r_e_key  <= node_q;
            r_e_cost <= cost_q;
            r_e_cv   <= cv_j;
        end
        if (i_ctl.emit) begin
            r_prev_key <= r_e_key;
            r_okey     <= r_e_key;
            r_ocost    <= r_e_cv ? r_e_cost : '0;
            r_oreach   <= r_e_cv;
            r_olast    <= (r_out_cnt + NW'(1)) == (r_count - NW'(1));
        end
    end

    always_comb begin
        o_sts.clr_done  = (r_clr == EAW'(sssp_pkg::EDGES - 1));
        o_sts.scan_done = (r_idx == r_count) && !r_pv;
        o_sts.found_a   = r_found_a;
        o_sts.found_b   = r_found_b;
        o_sts.full      = (r_count == NW'(NN));
        o_sts.min_found = r_min_found;
        o_sts.emit_done = (r_out_cnt == (r_count - NW'(1)));
        o_sts.out_free  = !r_ovalid || !i_stall;
        o_sts.cmd       = r_cmd;
    end

    assign o_valid     = r_ovalid;
    assign o_node_key  = r_okey;
    assign o_path_cost = r_ocost;
    assign o_reachable = r_oreach;
    assign o_last      = r_olast;

endmodule

/* src/single_source_shortest_path.sv */
// single_source_shortest_path.sv
// Top level of the shortest-path block: controller plus datapath.
// Depends on sssp_pkg, sssp_ctrl, sssp_dp.
//
// Input channel (i_valid / o_stall) takes one command per transaction:
// add node, add edge (cheaper of parallel edges kept) or run from source.
// Output channel (o_valid / i_stall) carries one transaction per node other
// than the source, in ascending key order, o_last on the final one.
// With n nodes loaded, every command starts with a lookup scan; add edge
// then reads and updates the edge table. A run makes (r + 1) relax scans
// for r reachable nodes besides the source, then n - 1 result scans.
// Scans use the single read port of each memory, one slot per cycle.
// Reset clears the node table and starts a clearing pass over the edge
// table: MAX_NODES * MAX_NODES entries (1024), with o_stall high.
// Each result goes to an output register; the next result scan runs while
// it waits, and the block holds when the following result is ready and the
// receiver still stalls. A new command is taken once the last result of a
// run is in the output register.
module single_source_shortest_path (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sssp_pkg::CMD_W-1:0]     i_cmd,
    input  logic [sssp_pkg::KEY_W-1:0]     i_key_a,
    input  logic [sssp_pkg::KEY_W-1:0]     i_key_b,
    input  logic [sssp_pkg::COST_W-1:0]    i_edge_cost,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sssp_pkg::KEY_W-1:0]     o_node_key,
    output logic [sssp_pkg::DIST_BITS-1:0] o_path_cost,
    output logic                           o_reachable,
    output logic                           o_last
);

    sssp_pkg::t_dp_cmd ctl;
    sssp_pkg::t_dp_sts sts;

    sssp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    sssp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cmd       (i_cmd),
        .i_key_a     (i_key_a),
        .i_key_b     (i_key_b),
        .i_edge_cost (i_edge_cost),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_node_key  (o_node_key),
        .o_path_cost (o_path_cost),
        .o_reachable (o_reachable),
        .o_last      (o_last)
    );

endmodule

/* src/sssp_checker.sv */
// sssp_checker.sv
// Port-level assertions for the shortest-path block, bound to its top level.
// Depends on sssp_pkg and single_source_shortest_path.
module sssp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [sssp_pkg::CMD_W-1:0]     i_cmd,
    input logic [sssp_pkg::KEY_W-1:0]     i_key_a,
    input logic [sssp_pkg::KEY_W-1:0]     i_key_b,
    input logic [sssp_pkg::COST_W-1:0]    i_edge_cost,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [sssp_pkg::KEY_W-1:0]     o_node_key,
    input logic [sssp_pkg::DIST_BITS-1:0] o_path_cost,
    input logic                           o_reachable,
    input logic                           o_last
);

    // reset starts the edge clear: no input, no result
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_stall && !o_valid))
        else $error("stall low or result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_node_key)
            && $stable(o_path_cost) && $stable(o_reachable) && $stable(o_last)))
        else $error("stalled result transaction changed");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reachable) |-> (o_path_cost == '0))
        else $error("unreachable node reported with nonzero cost");

    // a new run needs a lookup first, so a result never follows the last one
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !i_stall) |=> !o_valid)
        else $error("result transaction right after last of a run");

endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (.*);
